>>> rtl/deadline_ordered_timer_queue_core_defines.svh
// Assertion macros for the deadline-ordered timer queue.
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define DOTQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// Antecedent implies consequent in the next cycle.
`define DOTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

>>> rtl/dotq_pkg.sv
// Package with types, codes and helpers of the deadline-ordered timer queue.
package dotq_pkg;

  // Default sizes.
  localparam int DEPTH_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 8;

  // Fixed field widths.
  localparam int CMD_W    = 2;
  localparam int TIME_W   = 32;
  localparam int TASK_W   = 8;
  localparam int STATUS_W = 3;
  localparam int IN_DATA_W = 2 * TIME_W + TASK_W;

  // Command codes; the fourth code is unused.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_ACC_FRONT = 3'd1,
    ST_FULL      = 3'd2,
    ST_FIRED     = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_NONE      = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture the accepted input item
    logic step;   // perform one step and produce one result
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_valid;  // output register holds a result
    logic step_last;  // the result of this step ends the run
  } dp_sts_t;

  // True when a is strictly later than b in wrapping time.
  function automatic logic later_than(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

  // True when deadline minus now, read as signed, is at most zero.
  function automatic logic is_due(logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    d = dl - now;
    return (d == '0) || d[TIME_W-1];
  endfunction

endpackage

>>> rtl/dotq_ctrl.sv
// Controller state machine of the deadline-ordered timer queue.
module dotq_ctrl
  import dotq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [CMD_W-1:0]     s_command_i,
  input  logic                 m_tready_i,
  input  dp_sts_t              sts_i,
  output ctrl_cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   out_free;
  logic   cmd_known;

  // The output register can take a new result.
  assign out_free = !sts_i.out_valid || m_tready_i;

  // Commands that produce results.
  always_comb begin
    unique case (s_command_i) inside
      CMD_INSERT, CMD_TICK, CMD_STOP: cmd_known = 1'b1;
      default:                        cmd_known = 1'b0;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands to the datapath.
  always_comb begin
    state_d    = state_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          if (cmd_known) begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.step_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> rtl/dotq_datapath.sv
// Datapath of the deadline-ordered timer queue: sorted row and output register.
module dotq_datapath
  import dotq_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_sts_t              sts_o,
  input  logic [CMD_W-1:0]     s_command_i,
  input  logic [TIME_W-1:0]    s_deadline_i,
  input  logic [TASK_W-1:0]    s_task_i,
  input  logic [TIME_W-1:0]    s_now_i,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [TASK_W-1:0]    m_task_o,
  output logic [STATUS_W-1:0]  m_status_o,
  output logic                 m_tlast_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Sorted row, head at index zero.
  logic [TIME_W-1:0]      due_q [DEPTH];
  logic [TIME_W-1:0]      due_d [DEPTH];
  logic [HANDLE_BITS-1:0] hdl_q [DEPTH];
  logic [HANDLE_BITS-1:0] hdl_d [DEPTH];
  logic [CNT_W-1:0]       count_q, count_d;

  // Captured input item.
  cmd_e                   cmd_q;
  logic [TIME_W-1:0]      dl_q;
  logic [HANDLE_BITS-1:0] new_hdl_q;
  logic [TIME_W-1:0]      now_q;
  logic [DEPTH-1:0]       later_q, later_d;

  // Output register.
  logic                   out_valid_q;
  logic [TASK_W-1:0]      out_task_q, out_task_d;
  status_e                out_status_q, out_status_d;
  logic                   out_last_q, out_last_d;

  // Candidate rows for an insert and for removal of the head.
  logic [TIME_W-1:0]      ins_due [DEPTH];
  logic [HANDLE_BITS-1:0] ins_hdl [DEPTH];
  logic [TIME_W-1:0]      dn_due [DEPTH];
  logic [HANDLE_BITS-1:0] dn_hdl [DEPTH];
  logic [DEPTH-1:0]       keep;

  logic                   full;
  logic                   nonempty;
  logic                   head_due;
  logic                   next_due;
  logic                   more_than_one;

  assign full          = (count_q == CNT_W'(DEPTH));
  assign nonempty      = (count_q != '0);
  assign more_than_one = (count_q > CNT_W'(1));
  assign head_due      = is_due(due_q[0], now_q);
  assign next_due      = is_due(due_q[1], now_q);

  // Per-entry compare against the incoming deadline, taken at capture.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      later_d[i] = (CNT_W'(i) < count_q) && later_than(due_q[i], s_deadline_i);
    end
  end

  // Insert row: entries before the slot stay, the slot takes the new task,
  // entries after it move up by one.
  for (genvar g = 0; g < DEPTH; g++) begin : g_row
    localparam logic [DEPTH-1:0] LowMask = {DEPTH{1'b1}} >> (DEPTH - 1 - g);
    assign keep[g] = !(|(later_q & LowMask)) && (CNT_W'(g) < count_q);
    if (g == 0) begin : g_head
      assign ins_due[g] = keep[g] ? due_q[g] : dl_q;
      assign ins_hdl[g] = keep[g] ? hdl_q[g] : new_hdl_q;
    end else begin : g_body
      always_comb begin
        if (keep[g]) begin
          ins_due[g] = due_q[g];
          ins_hdl[g] = hdl_q[g];
        end else if (keep[g-1]) begin
          ins_due[g] = dl_q;
          ins_hdl[g] = new_hdl_q;
        end else begin
          ins_due[g] = due_q[g-1];
          ins_hdl[g] = hdl_q[g-1];
        end
      end
    end
    if (g == DEPTH - 1) begin : g_tail
      assign dn_due[g] = due_q[g];
      assign dn_hdl[g] = hdl_q[g];
    end else begin : g_shift
      assign dn_due[g] = due_q[g+1];
      assign dn_hdl[g] = hdl_q[g+1];
    end
  end

  // One step: next row, count and result.
  always_comb begin
    due_d        = due_q;
    hdl_d        = hdl_q;
    count_d      = count_q;
    out_task_d   = '0;
    out_status_d = ST_NONE;
    out_last_d   = 1'b1;
    case (cmd_q)
      CMD_INSERT: begin
        if (full) begin
          out_status_d = ST_FULL;
        end else begin
          due_d        = ins_due;
          hdl_d        = ins_hdl;
          count_d      = count_q + CNT_W'(1);
          out_status_d = keep[0] ? ST_ACCEPTED : ST_ACC_FRONT;
        end
      end
      CMD_TICK: begin
        if (nonempty && head_due) begin
          due_d        = dn_due;
          hdl_d        = dn_hdl;
          count_d      = count_q - CNT_W'(1);
          out_task_d   = TASK_W'(hdl_q[0]);
          out_status_d = ST_FIRED;
          out_last_d   = !(more_than_one && next_due);
        end
      end
      CMD_STOP: begin
        if (nonempty) begin
          due_d        = dn_due;
          hdl_d        = dn_hdl;
          count_d      = count_q - CNT_W'(1);
          out_task_d   = TASK_W'(hdl_q[0]);
          out_status_d = ST_CANCELLED;
          out_last_d   = !more_than_one;
        end
      end
      default: begin
        out_last_d = 1'b1;
      end
    endcase
  end

  // Row storage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      due_q <= due_d;
      hdl_q <= hdl_d;
    end
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.step) begin
      count_q <= count_d;
    end
  end

  // Capture of the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= cmd_e'(s_command_i);
      dl_q      <= s_deadline_i;
      new_hdl_q <= HANDLE_BITS'(s_task_i);
      now_q     <= s_now_i;
      later_q   <= later_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_task_q   <= out_task_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign sts_o.out_valid = out_valid_q;
  assign sts_o.step_last = out_last_d;

  assign m_tvalid_o = out_valid_q;
  assign m_task_o   = out_task_q;
  assign m_status_o = out_status_q;
  assign m_tlast_o  = out_last_q;

endmodule

>>> rtl/deadline_ordered_timer_queue_core.sv
// Top level of the deadline-ordered timer queue.
// The queue holds up to DEPTH tasks sorted by deadline in a row of registers, newer
// tasks after older ones of equal deadline. Each item is one transfer on the slave side;
// the block takes one item at a time. An insert takes the transfer, in which every stored
// deadline is compared against the new one in parallel, and then one step in which the
// row opens a slot, unless it is full, and the status result is written. A tick or a
// stop takes the transfer and then one step per result, since each fired or cancelled
// entry leaves the head of the row through the single output register; a stalled
// master side stretches this. The next item may be taken while the last result still
// waits in the output register. An unused command code is taken and gives no result.
`include "deadline_ordered_timer_queue_core_defines.svh"

module deadline_ordered_timer_queue_core
  import dotq_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: deadline [31:0], task_id [39:32], now_time [71:40]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: command [1:0]
  input  logic [CMD_W-1:0]      s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: out_task [7:0]
  output logic [TASK_W-1:0]     m_axis_tdata_o,
  // tuser: status [2:0]
  output logic [STATUS_W-1:0]   m_axis_tuser_o,
  // tlast: last_of_run
  output logic                  m_axis_tlast_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;
  logic      in_known_xfer;
  logic      out_single;

  // Controller.
  dotq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_command_i (s_axis_tuser_i),
    .m_tready_i  (m_axis_tready_i),
    .sts_i       (dp_sts),
    .cmd_o       (ctrl_cmd)
  );

  // Datapath.
  dotq_datapath #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .sts_o        (dp_sts),
    .s_command_i  (s_axis_tuser_i),
    .s_deadline_i (s_axis_tdata_i[TIME_W-1:0]),
    .s_task_i     (s_axis_tdata_i[TIME_W +: TASK_W]),
    .s_now_i      (s_axis_tdata_i[TIME_W+TASK_W +: TIME_W]),
    .m_tready_i   (m_axis_tready_i),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_task_o     (m_axis_tdata_o),
    .m_status_o   (m_axis_tuser_o),
    .m_tlast_o    (m_axis_tlast_o)
  );

  // Input transfer of a command that gives results.
  assign in_known_xfer = s_axis_tvalid_i && s_axis_tready_o &&
                         (s_axis_tuser_i inside {CMD_INSERT, CMD_TICK, CMD_STOP});

  // Valid result whose status never has a follower in its run.
  assign out_single = m_axis_tvalid_o &&
                      (m_axis_tuser_o inside {ST_ACCEPTED, ST_ACC_FRONT, ST_FULL, ST_NONE});

  // A command that gives results blocks further input in the next cycle.
  `DOTQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_known_xfer, !s_axis_tready_o)

  // Every step shows a result on the master side in the next cycle.
  `DOTQ_ASSERT_NEXT(a_step_shows_result, clk_i, rst_ni, ctrl_cmd.step, m_axis_tvalid_o)

  // Single-result statuses always close their run.
  `DOTQ_ASSERT_SAME(a_single_is_last, clk_i, rst_ni, out_single, m_axis_tlast_o)

endmodule

>>> tb/tb_deadline_ordered_timer_queue_core.sv
// Self-checking testbench for the deadline-ordered timer queue core.
`timescale 1ns / 1ps

module tb_deadline_ordered_timer_queue_core;
  import dotq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One command item as it travels on the slave side.
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] deadline;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] now_time;
  } tq_item_t;

  // One result item as it is expected on the master side.
  typedef struct {
    status_e           status;
    logic [TASK_W-1:0] handle;
    logic              last;
  } tq_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i;
  logic [CMD_W-1:0]     s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [TASK_W-1:0]    m_axis_tdata_o;
  logic [STATUS_W-1:0]  m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  tq_item_t drv_item = '{cmd: '0, deadline: '0, task_id: '0, now_time: '0};

  // Stimulus waiting to be sent and results still owed by the block.
  tq_item_t   pending_items[$];
  tq_result_t expected_results[$];

  // Predicted queue contents, head at index zero.
  logic [TIME_W-1:0] model_due[$];
  logic [TASK_W-1:0] model_handle[$];

  logic in_taken     = 1'b0;
  int   items_taken  = 0;
  int   mismatch_cnt = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  logic calm;

  // tdata: deadline [31:0], task_id [39:32], now_time [71:40]
  assign s_axis_tdata_i = {drv_item.now_time, drv_item.task_id, drv_item.deadline};
  // tuser: command [1:0]
  assign s_axis_tuser_i = drv_item.cmd;

  // No idling on either side during this window of transfers.
  assign calm = (items_taken >= 150) && (items_taken < 210);

  deadline_ordered_timer_queue_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  // A strictly later than b when the wrapped difference is positive.
  function automatic logic runs_after(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic signed [TIME_W-1:0] diff;
    diff = a - b;
    return diff > 0;
  endfunction

  // An entry is due when its deadline minus now is at most zero.
  function automatic logic deadline_due(logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
    logic signed [TIME_W-1:0] diff;
    diff = dl - now;
    return diff <= 0;
  endfunction

  // Updates the predicted queue for one command and queues the results it owes.
  function automatic void timer_queue_apply(tq_item_t it);
    tq_result_t run[$];
    int         pos;
    if (it.cmd == CMD_INSERT) begin
      if (model_due.size() >= QDEPTH) begin
        run.push_back('{ST_FULL, '0, 1'b0});
      end else begin
        pos = model_due.size();
        for (int i = 0; i < model_due.size(); i++) begin
          if (runs_after(model_due[i], it.deadline)) begin
            pos = i;
            break;
          end
        end
        model_due.insert(pos, it.deadline);
        model_handle.insert(pos, it.task_id);
        run.push_back('{(pos == 0) ? ST_ACC_FRONT : ST_ACCEPTED, '0, 1'b0});
      end
    end else if (it.cmd == CMD_TICK) begin
      while (model_due.size() > 0 && deadline_due(model_due[0], it.now_time)) begin
        run.push_back('{ST_FIRED, model_handle[0], 1'b0});
        model_due.delete(0);
        model_handle.delete(0);
      end
    end else if (it.cmd == CMD_STOP) begin
      while (model_due.size() > 0) begin
        run.push_back('{ST_CANCELLED, model_handle[0], 1'b0});
        model_due.delete(0);
        model_handle.delete(0);
      end
    end else begin
      return;
    end
    // A tick or a stop that touches no entry still reports once.
    if (run.size() == 0) run.push_back('{ST_NONE, '0, 1'b0});
    run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_results.push_back(run[i]);
  endfunction

  function automatic void add_item(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] dl,
                                   logic [TASK_W-1:0] id, logic [TIME_W-1:0] now);
    tq_item_t it;
    it.cmd      = cmd;
    it.deadline = dl;
    it.task_id  = id;
    it.now_time = now;
    pending_items.push_back(it);
  endfunction

  // Driver: presents items and the receiver's ready on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 27)) begin
          drv_item        <= pending_items[0];
          pending_items.delete(0);
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 27);
    end
  end

  // Long receiver hold-off while the sender keeps offering items.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= 80) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk_i) begin
    tq_result_t exp_r;
    int         errs;
    errs = 0;
    in_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      timer_queue_apply(drv_item);
      items_taken <= items_taken + 1;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        $error("result without expectation: status %0d out_task %0d last_of_run %0d",
               m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        errs++;
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        if (m_axis_tuser_o !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, m_axis_tuser_o);
          errs++;
        end
        if (m_axis_tdata_o !== exp_r.handle) begin
          $error("out_task: expected %0d, actual %0d", exp_r.handle, m_axis_tdata_o);
          errs++;
        end
        if (m_axis_tlast_o !== exp_r.last) begin
          $error("last_of_run: expected %0d, actual %0d", exp_r.last, m_axis_tlast_o);
          errs++;
        end
      end
    end
    if (errs != 0) mismatch_cnt <= mismatch_cnt + errs;
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [TIME_W-1:0] t_base;
    int                made;
    int                pick;

    // Directed: empty queue, wrap-around deadlines, equal deadlines, full queue.
    add_item(CMD_TICK,   $urandom(), 8'($urandom()), 32'd0);
    add_item(CMD_STOP,   $urandom(), 8'($urandom()), $urandom());
    add_item(CMD_INSERT, 32'd100, 8'd0, $urandom());
    add_item(CMD_INSERT, 32'd100, 8'd255, $urandom());
    add_item(CMD_INSERT, 32'd50, 8'd7, $urandom());
    add_item(CMD_INSERT, 32'hFFFF_FFFF, 8'd1, $urandom());
    add_item(CMD_INSERT, 32'd0, 8'd2, 32'hFFFF_FFFF);
    add_item(CMD_TICK,   32'hFFFF_FFFF, 8'd255, 32'd60);
    add_item(CMD_TICK,   $urandom(), 8'($urandom()), 32'd99);
    add_item(CMD_UNUSED, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
    for (int i = 0; i < QDEPTH - 2; i++) begin
      add_item(CMD_INSERT, 32'd200 + 32'(3 * (i % 5)), 8'(17 * i + 3), $urandom());
    end
    add_item(CMD_INSERT, 32'd10, 8'd99, $urandom());
    add_item(CMD_STOP,   $urandom(), 8'($urandom()), $urandom());

    // Random: a running clock near the wrap point, with some noise items.
    t_base = 32'hFFFF_F000 + 32'($urandom_range(0, 2047));
    made   = 0;
    while (made < 270) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        add_item(CMD_INSERT, t_base + 32'($urandom_range(0, 400)) - 32'd20,
                 8'($urandom_range(0, 255)), $urandom());
      end else if (pick < 78) begin
        t_base = t_base + 32'($urandom_range(0, 120));
        add_item(CMD_TICK, $urandom(), 8'($urandom()), t_base);
      end else if (pick < 82) begin
        add_item(CMD_STOP, $urandom(), 8'($urandom()), $urandom());
      end else if (pick < 85) begin
        add_item(CMD_UNUSED, $urandom(), 8'($urandom()), $urandom());
      end else if (pick < 92) begin
        add_item(CMD_INSERT, $urandom(), 8'($urandom()), $urandom());
      end else begin
        add_item(CMD_TICK, $urandom(), 8'($urandom()), $urandom());
      end
      if (pick < 82 || pick >= 85) made++;
    end

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || s_axis_tvalid_i) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> deadline_ordered_timer_queue_core.f
+incdir+rtl
rtl/dotq_pkg.sv
rtl/dotq_ctrl.sv
rtl/dotq_datapath.sv
rtl/deadline_ordered_timer_queue_core.sv
tb/tb_deadline_ordered_timer_queue_core.sv
